// ===== rtl/lbor_pkg.sv =====
// Package for the layered box overlap registry: shared types, codes and widths.
// No dependencies.
package lbor_pkg;
    localparam int unsigned SLOTS_DEF = 64;
    localparam int unsigned MAX_HITS_DEF = 8;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_UPDATE   = 2'd1,
        ACT_CHECK    = 2'd2,
        ACT_REMOVE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_box;

    typedef struct packed {
        logic [15:0] layer;
        logic [15:0] collide;
    } t_masks;

    // Query broadcast into the cell row.
    typedef struct packed {
        t_box        box;
        logic [15:0] collide;
    } t_query;

    // Strict overlap of two boxes; empty boxes never overlap.
    function automatic logic boxes_overlap(t_box a, t_box b);
        logic signed [17:0] ax_end;
        logic signed [17:0] bx_end;
        logic signed [17:0] ay_end;
        logic signed [17:0] by_end;
        ax_end = 18'(a.x) + 18'($signed({1'b0, a.w}));
        bx_end = 18'(b.x) + 18'($signed({1'b0, b.w}));
        ay_end = 18'(a.y) + 18'($signed({1'b0, a.h}));
        by_end = 18'(b.y) + 18'($signed({1'b0, b.h}));
        if (a.w == '0 || a.h == '0 || b.w == '0 || b.h == '0) begin
            return 1'b0;
        end
        return (18'(a.x) < bx_end) && (18'(b.x) < ax_end)
            && (18'(a.y) < by_end) && (18'(b.y) < ay_end);
    endfunction
endpackage

// ===== rtl/lbor_cell.sv =====
// One table slot: box, masks and active flag, plus a stage of the scan token chain.
// Depends on lbor_pkg.
module lbor_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_box,
    input  logic                  i_wr_masks,
    input  logic                  i_set_active,
    input  logic                  i_clr_active,
    input  lbor_pkg::t_box        i_box,
    input  lbor_pkg::t_masks      i_masks,
    input  logic                  i_tok_clear,
    input  logic                  i_tok_in,
    input  logic                  i_tok_stall,
    input  logic                  i_is_self,
    input  lbor_pkg::t_query      i_query,
    output logic                  o_tok_out,
    output logic                  o_active,
    output logic                  o_match,
    output lbor_pkg::t_box        o_box,
    output lbor_pkg::t_masks      o_masks
);
    import lbor_pkg::*;

    t_box   r_box;
    t_masks r_masks;
    logic   r_active;
    logic   r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tok    <= 1'b0;
        end else begin
            if (i_set_active) begin
                r_active <= 1'b1;
            end else if (i_clr_active) begin
                r_active <= 1'b0;
            end
            if (i_tok_clear) begin
                r_tok <= 1'b0;
            end else if (!i_tok_stall) begin
                r_tok <= i_tok_in;
            end
        end
        if (i_wr_box) begin
            r_box <= i_box;
        end
        if (i_wr_masks) begin
            r_masks <= i_masks;
        end
    end

    assign o_tok_out = r_tok;
    assign o_active  = r_active;
    assign o_box     = r_box;
    assign o_masks   = r_masks;
    // Hit test while the scan token rests here.
    assign o_match = r_tok && r_active && !i_is_self
        && ((r_masks.layer & i_query.collide) != '0)
        && boxes_overlap(r_box, i_query.box);
endmodule

// ===== rtl/layered_box_overlap_registry_top.sv =====
// Top level of the layered box overlap registry: control sequencer and cell row.
// Depends on lbor_pkg and lbor_cell.
module layered_box_overlap_registry_top #(
    parameter int unsigned SLOTS    = lbor_pkg::SLOTS_DEF,
    parameter int unsigned MAX_HITS = lbor_pkg::MAX_HITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_slot,
    input  logic signed [15:0] i_box_x,
    input  logic signed [15:0] i_box_y,
    input  logic [14:0] i_box_w,
    input  logic [14:0] i_box_h,
    input  logic [15:0] i_layer_bits,
    input  logic [15:0] i_collide_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_slot,
    output logic        o_hit,
    output logic        o_last
);
    // A table of SLOTS boxes held in a row of cells. Register, update and remove
    // present their result the cycle after acceptance; the next request is taken
    // once that result has been accepted. A check passes a one-hot token down the
    // cell row, one slot per cycle while the token is not held, then closes the
    // request in S_OUT once the output register is free. Each hit is held back
    // in a pending register until the next hit or the end of the scan shows
    // whether it is the last one; the token stops only when a new hit arrives
    // while the previous result still waits to be taken. The scan ends early
    // after MAX_HITS hits. One request is worked on at a time.
    import lbor_pkg::*;

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned HW = $clog2(MAX_HITS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} t_state;

    t_state         r_state;
    t_query         r_query;
    logic [SW-1:0]  r_self;
    logic [SW-1:0]  r_pos;
    logic [HW-1:0]  r_hits;
    logic           r_pend;
    logic [SW-1:0]  r_pslot;
    logic           r_ovalid;
    logic [1:0]     r_status;
    logic [5:0]     r_rslot;
    logic           r_hit;
    logic           r_last;

    logic [SLOTS-1:0] w_active;
    logic [SLOTS-1:0] w_match;
    logic [SLOTS:0]   w_tok;
    t_box             w_box   [SLOTS];
    t_masks           w_masks [SLOTS];

    logic             w_acc;
    logic             w_out_free;
    logic             w_load;
    logic             w_tok_stall;
    logic             w_tok_start;
    logic [SW-1:0]    w_free_idx;
    logic             w_free_found;
    logic             w_slot_ok;
    logic             w_any_match;
    logic             w_scan_end;
    logic [SLOTS-1:0] w_wr_box;
    logic [SLOTS-1:0] w_wr_masks;
    logic [SLOTS-1:0] w_set;
    logic [SLOTS-1:0] w_clr;
    t_box             w_in_box;
    t_masks           w_in_masks;
    t_action          w_act;

    assign w_act      = t_action'(i_action);
    assign w_in_box   = '{x: i_box_x, y: i_box_y, w: i_box_w, h: i_box_h};
    assign w_in_masks = '{layer: i_layer_bits, collide: i_collide_mask};
    assign o_ready    = (r_state == S_IDLE) && !r_ovalid;
    assign w_acc      = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_slot_ok  = (32'(i_slot) < SLOTS) && w_active[SW'(i_slot)];

    // Lowest free slot: priority search.
    always_comb begin
        w_free_idx   = '0;
        w_free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!w_active[i]) begin
                w_free_idx   = SW'(i);
                w_free_found = 1'b1;
            end
        end
    end

    always_comb begin
        w_wr_box   = '0;
        w_wr_masks = '0;
        w_set      = '0;
        w_clr      = '0;
        if (w_acc) begin
            case (w_act)
                ACT_REGISTER: begin
                    if (w_free_found) begin
                        w_wr_box[w_free_idx]   = 1'b1;
                        w_wr_masks[w_free_idx] = 1'b1;
                        w_set[w_free_idx]      = 1'b1;
                    end
                end
                ACT_UPDATE: begin
                    if (w_slot_ok) w_wr_box[SW'(i_slot)] = 1'b1;
                end
                ACT_REMOVE: begin
                    if (w_slot_ok) w_clr[SW'(i_slot)] = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_any_match = |w_match;
    // Hold the token on a hit while the previous hit cannot yet move out.
    assign w_tok_stall = (r_state == S_SCAN) && w_any_match && r_pend && !w_out_free;
    assign w_tok_start = w_acc && (w_act == ACT_CHECK) && w_slot_ok;
    assign w_tok[0]    = w_tok_start;
    // This hit is the final one the scan can produce.
    assign w_scan_end  = (32'(r_hits) + 1 == MAX_HITS) || (32'(r_pos) == SLOTS - 1);

    // A new result enters the output register this cycle.
    always_comb begin
        case (r_state)
            S_IDLE:  w_load = w_acc && !w_tok_start;
            S_SCAN:  w_load = !w_tok_stall && w_any_match && r_pend;
            S_OUT:   w_load = w_out_free;
            default: w_load = 1'b0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            lbor_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_wr_box     (w_wr_box[g]),
                .i_wr_masks   (w_wr_masks[g]),
                .i_set_active (w_set[g]),
                .i_clr_active (w_clr[g]),
                .i_box        (w_in_box),
                .i_masks      (w_in_masks),
                .i_tok_clear  (r_state == S_OUT),
                .i_tok_in     (w_tok[g]),
                .i_tok_stall  (w_tok_stall),
                .i_is_self    (r_self == SW'(g)),
                .i_query      (r_query),
                .o_tok_out    (w_tok[g+1]),
                .o_active     (w_active[g]),
                .o_match      (w_match[g]),
                .o_box        (w_box[g]),
                .o_masks      (w_masks[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_hits   <= '0;
            r_pos    <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (w_act)
                            ACT_REGISTER: begin
                                r_status <= w_free_found ? ST_OK : ST_FULL;
                                r_rslot  <= w_free_found ? 6'(w_free_idx) : '0;
                                r_hit    <= 1'b0;
                                r_last   <= 1'b1;
                            end
                            ACT_CHECK: begin
                                if (w_slot_ok) begin
                                    // Latch the query from the slot's own cell.
                                    r_query.box     <= w_box[SW'(i_slot)];
                                    r_query.collide <= w_masks[SW'(i_slot)].collide;
                                    r_self  <= SW'(i_slot);
                                    r_pos   <= '0;
                                    r_hits  <= '0;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_status <= ST_INACTIVE;
                                    r_rslot  <= '0;
                                    r_hit    <= 1'b0;
                                    r_last   <= 1'b1;
                                end
                            end
                            default: begin
                                r_status <= w_slot_ok ? ST_OK : ST_INACTIVE;
                                r_rslot  <= '0;
                                r_hit    <= 1'b0;
                                r_last   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!w_tok_stall) begin
                        if (w_any_match) begin
                            // Release the earlier hit, hold the new one back.
                            if (r_pend) begin
                                r_status <= ST_OK;
                                r_hit    <= 1'b1;
                                r_rslot  <= 6'(r_pslot);
                                r_last   <= 1'b0;
                            end
                            r_pend  <= 1'b1;
                            r_pslot <= r_pos;
                            r_hits  <= r_hits + 1'b1;
                            if (w_scan_end) begin
                                r_state <= S_OUT;
                            end
                        end else if (32'(r_pos) == SLOTS - 1) begin
                            // Scan over with no further hit.
                            r_state <= S_OUT;
                        end
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_OUT: begin
                    // Close the request: the held hit, or a single no-hit result.
                    if (w_out_free) begin
                        r_status <= ST_OK;
                        r_hit    <= r_pend;
                        r_rslot  <= r_pend ? 6'(r_pslot) : '0;
                        r_last   <= 1'b1;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_result_slot = r_rslot;
    assign o_hit         = r_hit;
    assign o_last        = r_last;
endmodule

// ===== dv/tb.sv =====
// Testbench for layered_box_overlap_registry_top: random and directed table requests
// checked against an in-bench predictor of the box table. Depends on lbor_pkg and the RTL.
module tb;
    import lbor_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic [15:0] layer;
        logic [15:0] collide;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] rslot;
        logic       hit;
        logic       last;
    } t_answer;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [5:0]  i_slot;
    logic signed [15:0] i_box_x;
    logic signed [15:0] i_box_y;
    logic [14:0] i_box_w;
    logic [14:0] i_box_h;
    logic [15:0] i_layer_bits;
    logic [15:0] i_collide_mask;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [5:0]  o_result_slot;
    logic        o_hit;
    logic        o_last;

    layered_box_overlap_registry_top dut (.*);

    // Predictor state: mirror of the table.
    logic   live[64];
    t_box   boxes[64];
    t_masks masks[64];

    t_request pending_q[$];
    t_answer  answer_q[$];
    int  errors;
    bit  stim_done;
    bit  calm;        // last stretch: no idling on either side
    bit  hold_rx;     // request a long receiver hold-off
    int  watchdog;

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    function automatic logic overlap_strict(t_box a, t_box b);
        int ax, ay, bx, by;
        ax = a.x; ay = a.y; bx = b.x; by = b.y;
        if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0) return 1'b0;
        return ax < bx + int'(b.w) && bx < ax + int'(a.w)
            && ay < by + int'(b.h) && by < ay + int'(a.h);
    endfunction

    // Work out the answers one request causes and advance the mirrored table.
    function automatic void predict_request(t_request r);
        t_answer a;
        t_box    b;
        int      id, n;
        b = '{x: r.x, y: r.y, w: r.w, h: r.h};
        a = '{status: ST_OK, rslot: 0, hit: 0, last: 1};
        if (t_action'(r.action) == ACT_REGISTER) begin
            id = -1;
            for (int i = 63; i >= 0; i--) if (!live[i]) id = i;
            if (id < 0) begin
                a.status = ST_FULL;
            end else begin
                live[id] = 1'b1;
                boxes[id] = b;
                masks[id] = '{layer: r.layer, collide: r.collide};
                a.rslot = id[5:0];
            end
            answer_q.push_back(a);
            return;
        end
        if (!live[r.slot]) begin
            a.status = ST_INACTIVE;
            answer_q.push_back(a);
            return;
        end
        case (t_action'(r.action))
            ACT_UPDATE: boxes[r.slot] = b;
            ACT_REMOVE: live[r.slot] = 1'b0;
            default: begin
                n = 0;
                for (int i = 0; i < 64 && n < MAX_HITS_DEF; i++) begin
                    if (i != r.slot && live[i]
                        && (masks[r.slot].collide & masks[i].layer) != 0
                        && overlap_strict(boxes[r.slot], boxes[i])) begin
                        answer_q.push_back('{status: ST_OK, rslot: i[5:0], hit: 1, last: 0});
                        n++;
                    end
                end
                if (n > 0) begin
                    answer_q[$].last = 1'b1;
                    return;
                end
            end
        endcase
        answer_q.push_back(a);
    endfunction

    function automatic t_request make_request(logic [1:0] act, logic [5:0] slot,
                                              int x, int y, int w, int h,
                                              logic [15:0] lay, logic [15:0] col);
        t_request r;
        r.action = act; r.slot = slot;
        r.x = x[15:0]; r.y = y[15:0]; r.w = w[14:0]; r.h = h[14:0];
        r.layer = lay; r.collide = col;
        return r;
    endfunction

    // Mostly clustered boxes so that checks find hits; sometimes full-range fields.
    function automatic t_request random_request(int target);
        t_request r;
        logic [1:0] act;
        r = '{default: '0};
        act = $urandom_range(3, 0);
        r.action = act;
        r.slot = ($urandom_range(3, 0) == 0) ? 6'($urandom) : 6'($urandom_range(target, 0));
        if ($urandom_range(5, 0) == 0) begin
            r.x = 16'($urandom); r.y = 16'($urandom);
            r.w = 15'($urandom); r.h = 15'($urandom);
            r.layer = 16'($urandom); r.collide = 16'($urandom);
        end else begin
            r.x = 16'($urandom_range(200, 0) - 100);
            r.y = 16'($urandom_range(200, 0) - 100);
            r.w = 15'($urandom_range(120, 0));
            r.h = 15'($urandom_range(120, 0));
            r.layer = 16'(1 << $urandom_range(3, 0)) | 16'($urandom_range(1, 0) << 15);
            r.collide = 16'($urandom_range(16'hffff, 0)) | 16'h000f;
        end
        return r;
    endfunction

    initial begin
        t_request r;
        int target;
        errors = 0;
        stim_done = 1'b0;
        calm = 1'b0;
        hold_rx = 1'b0;
        for (int i = 0; i < 64; i++) begin
            live[i] = 1'b0;
            boxes[i] = '0;
            masks[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: inactive slots, touching edges, empty boxes, extremes, self check.
        pending_q.push_back(make_request(ACT_CHECK, 6'd63, 0, 0, 1, 1, 0, 0));
        pending_q.push_back(make_request(ACT_UPDATE, 6'd5, 0, 0, 1, 1, 0, 0));
        pending_q.push_back(make_request(ACT_REMOVE, 6'd0, 0, 0, 1, 1, 0, 0));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd63, 0, 0, 10, 10, 16'h0001, 16'hffff));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, 10, 0, 10, 10, 16'h0001, 16'hffff));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, 9, 9, 5, 5, 16'h0002, 16'h0001));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, 2, 2, 0, 5, 16'hffff, 16'hffff));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, -32768, -32768, 32767, 32767,
                                         16'h8000, 16'h8000));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, 32767, 32767, 32767, 32767,
                                         16'h8000, 16'h8000));
        pending_q.push_back(make_request(ACT_CHECK, 6'd0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_CHECK, 6'd2, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_CHECK, 6'd4, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_UPDATE, 6'd4, -1, -1, 32767, 32767, 0, 0));
        pending_q.push_back(make_request(ACT_CHECK, 6'd4, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_UPDATE, 6'd1, 5, 5, 1, 0, 0, 0));
        pending_q.push_back(make_request(ACT_CHECK, 6'd3, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_REMOVE, 6'd1, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_REMOVE, 6'd1, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_request(ACT_REGISTER, 6'd0, 0, 0, 40, 40, 16'h0001, 16'h0001));

        // Fill the table to overflow, then check with many hits.
        for (int i = 0; i < 62; i++)
            pending_q.push_back(make_request(ACT_REGISTER, 6'($urandom), 0, 0, 50, 50,
                                             16'h0001, 16'hffff));
        for (int i = 0; i < 4; i++)
            pending_q.push_back(make_request(ACT_CHECK, 6'($urandom_range(63, 0)), 0, 0, 0, 0, 0, 0));
        hold_rx = 1'b1;
        for (int i = 0; i < 40; i++)
            pending_q.push_back(make_request(ACT_REMOVE, 6'($urandom), 0, 0, 0, 0, 0, 0));

        // Random part: the slot range mostly alternates between 0 to 15 and 0 to 63 in runs of 50 requests.
        for (int i = 0; i < 300; i++) begin
            target = (i % 100 < 50) ? 15 : 63;
            r = random_request(target);
            pending_q.push_back(r);
            if (i == 240) begin
                wait (pending_q.size() < 80);
                calm = 1'b1;
            end
        end
        wait (pending_q.size() == 0 && !i_valid);
        stim_done = 1'b1;
    end

    // Driver: present requests from the queue, with random idle bursts.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
            {i_action, i_slot, i_box_x, i_box_y, i_box_w, i_box_h,
             i_layer_bits, i_collide_mask} <= '0;
        end else if (i_valid && !o_ready) begin
            // hold the request until accepted
        end else begin
            // an accepted request leaves the queue, so the head is always next
            if (i_valid) predict_request(pending_q.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(5, 0) == 0) begin
                gap_left <= $urandom_range(16, 0);
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                r_drive(pending_q[0]);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic r_drive(t_request r);
        i_valid <= 1'b1;
        i_action <= r.action;
        i_slot <= r.slot;
        i_box_x <= r.x;
        i_box_y <= r.y;
        i_box_w <= r.w;
        i_box_h <= r.h;
        i_layer_bits <= r.layer;
        i_collide_mask <= r.collide;
    endtask

    // Receiver stall: random bursts, plus one long hold-off so the input backs up.
    int stall_left;
    bit held;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
            held <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (hold_rx && !held) begin
            held <= 1'b1;
            stall_left <= 600;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(4, 0) == 0) begin
            stall_left <= $urandom_range(16, 0);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted answer with the oldest expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected answer status=%0d slot=%0d hit=%0d last=%0d",
                         $time, o_status, o_result_slot, o_hit, o_last);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (o_status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                if (o_result_slot !== want.rslot)
                    $display("%0t: result_slot expected %0d actual %0d", $time, want.rslot,
                             o_result_slot);
                if (o_hit !== want.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, o_hit);
                if (o_last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time, want.last, o_last);
                if (o_status !== want.status || o_result_slot !== want.rslot
                    || o_hit !== want.hit || o_last !== want.last)
                    errors++;
            end
        end
    end

    // Watchdog: cycles without any handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        fork
            begin
                wait (stim_done && answer_q.size() == 0);
                repeat (100) @(posedge i_clk);
                if (errors == 0 && answer_q.size() == 0)
                    $display("TB_OK");
                else
                    $display("TB_ERROR");
            end
            begin
                wait (watchdog >= WATCHDOG_LIMIT);
                $display("TB_ERROR");
            end
        join_any
        $finish;
    end
endmodule
